[design/ura_pkg.sv]
// Shared types, constants and the digit glyph function for the radix-to-ASCII converter.
`timescale 1ns / 1ps

package ura_pkg;

    typedef logic [3:0] t_digit;
    typedef logic [4:0] t_radix;

    localparam logic [7:0] C_BASE_MIN  = 8'd2;
    localparam logic [7:0] C_BASE_MAX  = 8'd16;
    localparam int         C_STEP_BITS = 8;
    localparam logic [7:0] C_CHAR_ZERO = 8'h30;
    localparam logic [7:0] C_CHAR_A    = 8'h61;
    localparam t_digit     C_DEC_TOP   = 4'd10;

    function automatic logic [7:0] f_glyph(input t_digit d);
        logic [7:0] c;
        if (d < C_DEC_TOP) begin
            c = C_CHAR_ZERO + {4'd0, d};
        end else begin
            c = C_CHAR_A + {4'd0, d - C_DEC_TOP};
        end
        return c;
    endfunction

endpackage

[design/ura_if.sv]
// Valid/ready channel interfaces for the input items and the digit results.
`timescale 1ns / 1ps

interface ura_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [7:0]  base;

    modport source (output valid, output value, output base, input ready);
    modport sink   (input valid, input value, input base, output ready);
endinterface

interface ura_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] digit_char;
    logic       bad_base;
    logic       last;

    modport source (output valid, output digit_char, output bad_base, output last, input ready);
    modport sink   (input valid, input digit_char, input bad_base, input last, output ready);
endinterface

[design/ura_div.sv]
// Iterative divider by a small radix, eight dividend bits per cycle.
`timescale 1ns / 1ps

module ura_div #(
    parameter int PW = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [PW-1:0]        i_dividend,
    input  ura_pkg::t_radix      i_divisor,
    output logic                 o_done,
    output logic [PW-1:0]        o_quotient,
    output ura_pkg::t_digit      o_remainder
);

    localparam int CHUNKS = PW / ura_pkg::C_STEP_BITS;
    localparam int CW     = $clog2(CHUNKS + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [PW-1:0]         r_acc;
    ura_pkg::t_digit       r_rem;

    logic [PW-1:0]         n_acc;
    ura_pkg::t_digit       n_rem;

    always_comb begin
        logic [4:0] t;
        n_acc = r_acc;
        n_rem = r_rem;
        for (int i = 0; i < ura_pkg::C_STEP_BITS; i++) begin
            t = {n_rem, n_acc[PW-1]};
            n_acc = {n_acc[PW-2:0], 1'b0};
            if (t >= i_divisor) begin
                t = t - i_divisor;
                n_acc[0] = 1'b1;
            end
            n_rem = t[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_dividend;
            r_rem <= '0;
            r_cnt <= CW'(CHUNKS);
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_acc;
    assign o_remainder = r_rem;

endmodule

[design/unsigned_radix_to_ascii.sv]
// A bad base gives its single result the cycle after the input transfer.
// Otherwise the shared divider produces the digits one by one, least significant first,
// then each digit result passes a store read (ST_RD) and is held in ST_OUT until the sink is ready.
// One item at a time: a new input is taken only in idle, after the last result of the previous one.
// Reset: synchronous, active low; returns to idle, digit store contents are kept.
`timescale 1ns / 1ps

module unsigned_radix_to_ascii #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ura_in_if.sink        i_in,
    ura_out_if.source     o_out
);

    localparam int CHUNKS = (VALUE_BITS + ura_pkg::C_STEP_BITS - 1) / ura_pkg::C_STEP_BITS;
    localparam int PW     = CHUNKS * ura_pkg::C_STEP_BITS;
    localparam int AW     = $clog2(MAX_DIGITS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]            r_state;
    logic                  r_bad;
    logic [AW-1:0]         r_cnt;
    logic [AW-1:0]         r_idx;
    ura_pkg::t_radix       r_base;
    ura_pkg::t_digit       r_rd_data;
    ura_pkg::t_digit       r_store [MAX_DIGITS];

    logic                  s_in_xfer;
    logic                  s_out_xfer;
    logic                  s_base_bad;
    logic                  s_start;
    logic                  s_more;
    logic                  s_last;
    logic [PW-1:0]         s_dividend;
    logic                  div_done;
    logic [PW-1:0]         div_quo;
    ura_pkg::t_digit       div_rem;

    assign s_in_xfer  = i_in.valid && i_in.ready;
    assign s_out_xfer = o_out.valid && o_out.ready;
    assign s_base_bad = (i_in.base < ura_pkg::C_BASE_MIN) || (i_in.base > ura_pkg::C_BASE_MAX);
    assign s_more     = (div_quo != '0) && (r_cnt != AW'(MAX_DIGITS - 1));
    assign s_start    = (s_in_xfer && !s_base_bad) || (r_state == ST_DIV && div_done && s_more);
    assign s_dividend = (r_state == ST_IDLE) ? PW'(i_in.value[VALUE_BITS-1:0]) : div_quo;
    assign s_last     = r_bad || (r_idx == '0);

    ura_div #(
        .PW (PW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_start),
        .i_dividend  (s_dividend),
        .i_divisor   (r_state == ST_IDLE ? i_in.base[4:0] : r_base),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bad   <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (s_in_xfer) begin
                        r_bad   <= s_base_bad;
                        r_state <= s_base_bad ? ST_OUT : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done && !s_more) begin
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (s_out_xfer) begin
                        r_state <= s_last ? ST_IDLE : ST_RD;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_xfer) begin
            r_base <= i_in.base[4:0];
            r_cnt  <= '0;
        end else if (r_state == ST_DIV && div_done) begin
            if (s_more) begin
                r_cnt <= r_cnt + AW'(1);
            end else begin
                r_idx <= r_cnt;
            end
        end else if (r_state == ST_OUT && s_out_xfer && !s_last) begin
            r_idx <= r_idx - AW'(1);
        end
    end

    // digit store, least significant digit first
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && div_done) begin
            r_store[r_cnt] <= div_rem;
        end
        r_rd_data <= r_store[r_idx];
    end

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = (r_state == ST_OUT);
    assign o_out.digit_char = r_bad ? 8'd0 : ura_pkg::f_glyph(r_rd_data);
    assign o_out.bad_base   = r_bad;
    assign o_out.last       = s_last;

endmodule

[tb/unsigned_radix_to_ascii_tb.sv]
// Self-checking testbench: radix conversions on random handshakes, checked against a local predictor.
`timescale 1ns / 1ps

module unsigned_radix_to_ascii_tb;

    localparam int VALUE_BITS = 64;
    localparam int MAX_DIGITS = 64;
    localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);
    localparam logic [63:0] ALL_ONES = {64{1'b1}};

    typedef struct packed {
        logic [63:0] value;
        logic [7:0]  base;
    } t_conv_request;

    typedef struct packed {
        logic [7:0] digit_char;
        logic       bad_base;
        logic       last;
    } t_digit_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ura_in_if  in_if ();
    ura_out_if out_if ();

    unsigned_radix_to_ascii #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_DIGITS(MAX_DIGITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    t_conv_request pending_requests[$];
    t_digit_result expected_digits[$];
    int unsigned   requests_issued = 0;
    int unsigned   requests_taken  = 0;
    int unsigned   error_count     = 0;
    int unsigned   send_idle_pct   = 0;
    int unsigned   recv_stall_pct  = 0;
    logic          in_took         = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Digits of one conversion, most significant first
    function automatic void predict_digits(input logic [63:0] value, input logic [7:0] base);
        logic [3:0]    store [MAX_DIGITS];
        logic [63:0]   rest;
        logic [3:0]    d;
        int            n;
        t_digit_result r;
        if (base < ura_pkg::C_BASE_MIN || base > ura_pkg::C_BASE_MAX) begin
            r = '{digit_char: 8'd0, bad_base: 1'b1, last: 1'b1};
            expected_digits.push_back(r);
            return;
        end
        rest = value & VALUE_MASK;
        n = 0;
        do begin
            store[n] = 4'((rest % {56'd0, base}) & 64'hf);
            rest = rest / {56'd0, base};
            n++;
        end while (rest != 0 && n < MAX_DIGITS);
        for (int k = 0; k < n; k++) begin
            d = store[n - 1 - k];
            r.digit_char = (d < 4'd10) ? 8'(ura_pkg::C_CHAR_ZERO + d)
                                       : 8'(ura_pkg::C_CHAR_A + d - 4'd10);
            r.bad_base = 1'b0;
            r.last = (k == n - 1);
            expected_digits.push_back(r);
        end
    endfunction

    // Driver: inputs change on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            out_if.ready <= 1'b0;
        end else begin
            if (!in_if.valid || in_took) begin
                if (pending_requests.size() != 0
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    t_conv_request req;
                    req = pending_requests.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.value <= req.value;
                    in_if.base  <= req.base;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: transfers sampled on the rising edge
    always @(posedge i_clk) begin
        t_digit_result got;
        t_digit_result want;
        if (!i_rst_n) begin
            in_took = 1'b0;
        end else begin
            in_took = in_if.valid && in_if.ready;
            if (in_took) begin
                predict_digits(in_if.value, in_if.base);
                requests_taken++;
            end
            if (out_if.valid && out_if.ready) begin
                got = '{digit_char: out_if.digit_char, bad_base: out_if.bad_base,
                        last: out_if.last};
                if (expected_digits.size() == 0) begin
                    $display("%0t: unexpected result, got char %h bad_base %b last %b",
                             $time, got.digit_char, got.bad_base, got.last);
                    error_count++;
                end else begin
                    want = expected_digits.pop_front();
                    if (got.digit_char !== want.digit_char || got.bad_base !== want.bad_base
                            || got.last !== want.last) begin
                        $display({"%0t: mismatch, expected char %h bad_base %b last %b, ",
                                  "got char %h bad_base %b last %b"},
                                 $time, want.digit_char, want.bad_base, want.last,
                                 got.digit_char, got.bad_base, got.last);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic queue_request(input logic [63:0] value, input logic [7:0] base);
        t_conv_request req;
        req.value = value;
        req.base  = base;
        pending_requests.push_back(req);
        requests_issued++;
    endtask

    // Mostly narrow values to keep runs short; some full width, some bad radices
    task automatic queue_random(input int count);
        logic [63:0] v;
        logic [7:0]  b;
        int          w;
        int          pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                w = $urandom_range(1, 16);
            end else if (pick < 85) begin
                w = $urandom_range(17, 48);
            end else begin
                w = 64;
            end
            v = {$urandom, $urandom};
            if (w < 64) begin
                v = v & ((64'd1 << w) - 64'd1);
            end
            if ($urandom_range(0, 19) == 0) begin
                v = 64'd0;
            end
            if ($urandom_range(0, 9) == 0) begin
                b = $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(17, 255));
            end else begin
                b = 8'($urandom_range(2, 16));
            end
            queue_request(v, b);
        end
    endtask

    task automatic wait_drained;
        do begin
            @(negedge i_clk);
        end while (requests_taken != requests_issued || expected_digits.size() != 0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.value = 64'd0;
        in_if.base = 8'd0;
        out_if.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: zero, extremes, every radix, bad radices
        queue_request(64'd0, 8'd10);
        queue_request(64'd0, 8'd16);
        queue_request(ALL_ONES, 8'd2);
        queue_request(ALL_ONES, 8'd8);
        queue_request(ALL_ONES, 8'd10);
        queue_request(ALL_ONES, 8'd16);
        queue_request(64'd1, 8'd2);
        queue_request(64'd16, 8'd16);
        queue_request(64'd9, 8'd10);
        for (int b = 3; b <= 15; b++) begin
            if (b != 8 && b != 10) begin
                queue_request(64'h0123_4567_89ab_cdef, 8'(b));
            end
        end
        queue_request(ALL_ONES, 8'd0);
        queue_request(ALL_ONES, 8'd1);
        queue_request(ALL_ONES, 8'd17);
        queue_request(64'd0, 8'd255);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random(65);
        wait_drained();

        send_idle_pct = 47;
        recv_stall_pct = 0;
        queue_random(80);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 47;
        queue_random(80);
        wait_drained();

        send_idle_pct = 7;
        recv_stall_pct = 7;
        queue_random(80);
        wait_drained();

        repeat (50) @(negedge i_clk);
        if (error_count == 0) begin
            $display("unsigned_radix_to_ascii_tb passed");
        end else begin
            $display("unsigned_radix_to_ascii_tb failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("%0t: timeout", $time);
        $display("unsigned_radix_to_ascii_tb failed");
        $finish;
    end

endmodule
